FILE: rtl/core/md5bc_pkg.sv
package md5bc_pkg;

   localparam int WORD_W  = 32;
   localparam int INDEX_W = 4;
   localparam int ROUND_W = 6;
   localparam int STEP_W  = 3;
   localparam int JUMP_W  = 2;
   localparam int ROT_W   = 5;

   localparam logic [INDEX_W-1:0] LAST_WORD = 4'd15;
   localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;

   // request kinds
   localparam logic REQ_CHAIN = 1'b0;
   localparam logic REQ_MSG   = 1'b1;

   // microprogram addresses
   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_INIT  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_READ  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_ADDF  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_ADDM  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_ROT   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_FIN   = 3'd6;

   // sequencer jump kinds
   localparam logic [JUMP_W-1:0] JUMP_NEXT    = 2'd0;
   localparam logic [JUMP_W-1:0] JUMP_GOTO    = 2'd1;
   localparam logic [JUMP_W-1:0] JUMP_IF_GO   = 2'd2;
   localparam logic [JUMP_W-1:0] JUMP_IF_MORE = 2'd3;

   typedef struct packed {
      logic              accept;
      logic              init;
      logic              rd;
      logic              add_f;
      logic              add_m;
      logic              rotate;
      logic              finish;
      logic [JUMP_W-1:0] jump;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   localparam logic [WORD_W-1:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [ROT_W-1:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word used by a round
   function automatic logic [INDEX_W-1:0] msg_index(input logic [ROUND_W-1:0] rnd);
      logic [INDEX_W-1:0] lo;
      logic [INDEX_W-1:0] idx;
      lo = rnd[INDEX_W-1:0];
      case (rnd[ROUND_W-1:INDEX_W])
         2'd0: idx = lo;
         2'd1: idx = INDEX_W'(5 * int'(lo) + 1);
         2'd2: idx = INDEX_W'(3 * int'(lo) + 5);
         default: idx = INDEX_W'(7 * int'(lo));
      endcase
      return idx;
   endfunction

endpackage

FILE: rtl/core/md5_block_compress.sv
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             req_type, req_word_index, req_word_value
// response  out        rsp_valid (one cycle)     rsp_chain_a .. rsp_chain_d
//
// A chaining or message word write leaves busy low.
// A write of message word 15 starts a compression: busy is high for one load step,
// 64 rounds of four steps each, and one final add step.
// Each round is four steps set by the microprogram: memory read plus
// constant add, function add, message add, then rotate-add and register shift.
// The result strobes rsp_valid for one cycle just as busy falls; the receiver
// cannot stall, and a new transaction may be accepted in that same cycle.
// Reset is synchronous and active high; it zeroes the chaining words and
// returns the sequencer to idle. Message words are undefined until written.
module md5_block_compress (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [md5bc_pkg::INDEX_W-1:0]  req_word_index,
   input  logic [md5bc_pkg::WORD_W-1:0]   req_word_value,
   output logic                           rsp_valid,
   output logic [md5bc_pkg::WORD_W-1:0]   rsp_chain_a,
   output logic [md5bc_pkg::WORD_W-1:0]   rsp_chain_b,
   output logic [md5bc_pkg::WORD_W-1:0]   rsp_chain_c,
   output logic [md5bc_pkg::WORD_W-1:0]   rsp_chain_d
);
   import md5bc_pkg::*;

   ctrl_word_type ctrl;
   logic          last_round;

   // sequencer: step counter and control store
   md5bc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .word_index (req_word_index),
      .last_round (last_round),
      .ctrl       (ctrl),
      .busy       (busy)
   );

   // datapath: word stores, round registers and adders
   md5bc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .start      (start),
      .req_type   (req_type),
      .word_index (req_word_index),
      .word_value (req_word_value),
      .last_round (last_round),
      .rsp_valid  (rsp_valid),
      .chain_a    (rsp_chain_a),
      .chain_b    (rsp_chain_b),
      .chain_c    (rsp_chain_c),
      .chain_d    (rsp_chain_d)
   );

   // a compressing transaction must raise busy on the next cycle
   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_MSG) && (req_word_index == LAST_WORD)) |=> busy)
      else $error("busy did not rise after last message word");

   // results appear only as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // each result strobe lasts one cycle
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // a result follows a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy))
      else $error("result without a compression");

endmodule

FILE: rtl/core/md5bc_seq.sv
module md5bc_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           req_type,
   input  logic [md5bc_pkg::INDEX_W-1:0]  word_index,
   input  logic                           last_round,
   output md5bc_pkg::ctrl_word_type       ctrl,
   output logic                           busy
);
   import md5bc_pkg::*;

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   logic              go;

   // control store: one word per step
   function automatic ctrl_word_type rom_word(input logic [STEP_W-1:0] addr);
      ctrl_word_type w;
      w = '0;
      case (addr)
         STEP_IDLE: begin
            w.accept = 1'b1;
            w.jump   = JUMP_IF_GO;
            w.target = STEP_INIT;
         end
         STEP_INIT: begin
            w.init = 1'b1;
            w.jump = JUMP_NEXT;
         end
         STEP_READ: begin
            w.rd   = 1'b1;
            w.jump = JUMP_NEXT;
         end
         STEP_ADDF: begin
            w.add_f = 1'b1;
            w.jump  = JUMP_NEXT;
         end
         STEP_ADDM: begin
            w.add_m = 1'b1;
            w.jump  = JUMP_NEXT;
         end
         STEP_ROT: begin
            w.rotate = 1'b1;
            w.jump   = JUMP_IF_MORE;
            w.target = STEP_READ;
         end
         STEP_FIN: begin
            w.finish = 1'b1;
            w.jump   = JUMP_GOTO;
            w.target = STEP_IDLE;
         end
         default: begin
            w.jump   = JUMP_GOTO;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   assign ctrl = rom_word(pc_ff);
   assign busy = ~ctrl.accept;
   assign go   = ctrl.accept & start & (req_type == REQ_MSG) & (word_index == LAST_WORD);

   always_comb begin
      case (ctrl.jump)
         JUMP_NEXT:    pc_in = pc_ff + 1'b1;
         JUMP_GOTO:    pc_in = ctrl.target;
         JUMP_IF_GO:   pc_in = go ? ctrl.target : pc_ff;
         JUMP_IF_MORE: pc_in = last_round ? pc_ff + 1'b1 : ctrl.target;
         default:      pc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

FILE: rtl/core/md5bc_datapath.sv
module md5bc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  md5bc_pkg::ctrl_word_type       ctrl,
   input  logic                           start,
   input  logic                           req_type,
   input  logic [md5bc_pkg::INDEX_W-1:0]  word_index,
   input  logic [md5bc_pkg::WORD_W-1:0]   word_value,
   output logic                           last_round,
   output logic                           rsp_valid,
   output logic [md5bc_pkg::WORD_W-1:0]   chain_a,
   output logic [md5bc_pkg::WORD_W-1:0]   chain_b,
   output logic [md5bc_pkg::WORD_W-1:0]   chain_c,
   output logic [md5bc_pkg::WORD_W-1:0]   chain_d
);
   import md5bc_pkg::*;

   logic [WORD_W-1:0]  msg_mem [16];
   logic [WORD_W-1:0]  mem_q_ff;

   logic [WORD_W-1:0]  chain_ff [4];
   logic [WORD_W-1:0]  chain_in [4];
   logic               valid_ff;
   logic               valid_in;

   logic [WORD_W-1:0]  a_ff, b_ff, c_ff, d_ff;
   logic [WORD_W-1:0]  a_in, b_in, c_in, d_in;
   logic [WORD_W-1:0]  ak_ff, ak_in;
   logic [WORD_W-1:0]  sum_ff, sum_in;
   logic [ROUND_W-1:0] round_ff, round_in;

   logic               wr_en;
   logic [WORD_W-1:0]  f_val;
   logic [ROT_W-1:0]   rot_amt;
   logic [2*WORD_W-1:0] rot_wide;
   logic [WORD_W-1:0]  rotated;

   assign wr_en      = ctrl.accept & start;
   assign last_round = (round_ff == LAST_ROUND);

   always_comb begin
      case (round_ff[ROUND_W-1:INDEX_W])
         2'd0:    f_val = (b_ff & (c_ff ^ d_ff)) ^ d_ff;
         2'd1:    f_val = (d_ff & (b_ff ^ c_ff)) ^ c_ff;
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
   end

   assign rot_amt  = ROT_AMOUNT[{round_ff[ROUND_W-1:INDEX_W], round_ff[1:0]}];
   assign rot_wide = {sum_ff, sum_ff} << rot_amt;
   assign rotated  = rot_wide[2*WORD_W-1:WORD_W];

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      ak_in    = ak_ff;
      sum_in   = sum_ff;
      round_in = round_ff;
      chain_in = chain_ff;
      valid_in = ctrl.finish;

      if (wr_en && (req_type == REQ_CHAIN) && (word_index[INDEX_W-1:2] == 2'd0)) begin
         chain_in[word_index[1:0]] = word_value;
      end
      if (ctrl.init) begin
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         round_in = '0;
      end
      if (ctrl.rd) begin
         ak_in = a_ff + ROUND_CONST[round_ff];
      end
      if (ctrl.add_f) begin
         sum_in = ak_ff + f_val;
      end
      if (ctrl.add_m) begin
         sum_in = sum_ff + mem_q_ff;
      end
      if (ctrl.rotate) begin
         a_in     = d_ff;
         b_in     = b_ff + rotated;
         c_in     = b_ff;
         d_in     = c_ff;
         round_in = round_ff + 1'b1;
      end
      if (ctrl.finish) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
      end
   end

   // message store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en && (req_type == REQ_MSG)) begin
         msg_mem[word_index] <= word_value;
      end
      if (ctrl.rd) begin
         mem_q_ff <= msg_mem[msg_index(round_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            chain_ff[k] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      ak_ff    <= ak_in;
      sum_ff   <= sum_in;
      round_ff <= round_in;
   end

   assign rsp_valid = valid_ff;
   assign chain_a   = chain_ff[0];
   assign chain_b   = chain_ff[1];
   assign chain_c   = chain_ff[2];
   assign chain_d   = chain_ff[3];

endmodule

FILE: bench/md5_block_compress_tb.sv
module md5_block_compress_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import md5bc_pkg::*;

   // Watchdog: the slowest correct run (every transaction a compression plus a long
   // sender gap) stays well under this limit.
   localparam int CYCLE_LIMIT     = 3_000_000;
   // Settle time after the last digest: one full compression and some margin.
   localparam int DRAIN_CYCLES    = 300;
   // Counted transactions per idling phase; ignored chain writes do not count.
   localparam int ITEMS_PER_PHASE = 500;
   // Percent of cycles in which the sender holds start low, one entry per phase.
   localparam int PHASE_GAP [3]   = '{9, 85, 0};

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } digest_type;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] index;
      logic [WORD_W-1:0]  value;
      logic               has_digest;
      digest_type         digest;
   } plan_row_type;

   // Additive constants, floor(abs(sin(i + 1)) * 2^32).
   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Left rotation per round: row is the round group, column is round mod 4.
   localparam int SHIFT_AMT [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   // Directed plan. Fill the message store with the padded empty message, run
   // one compression on the zeroed chain left by reset, then load the standard
   // initial value and rerun on the stored words: that digest is the well-known
   // hash of the empty string. Ignored chain writes sit in between to catch
   // index aliasing, and the last rows hit the all-ones word extremes.
   localparam plan_row_type DIRECTED [25] = '{
      '{REQ_MSG,   4'd0,  32'h00000080, 1'b0, '0},
      '{REQ_MSG,   4'd1,  32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd2,  32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd3,  32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd4,  32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd5,  32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd6,  32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd7,  32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd8,  32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd9,  32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd10, 32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd11, 32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd12, 32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd13, 32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd14, 32'h00000000, 1'b0, '0},
      '{REQ_MSG,   4'd15, 32'h00000000, 1'b0, '0},
      '{REQ_CHAIN, 4'd0,  32'h67452301, 1'b0, '0},
      '{REQ_CHAIN, 4'd1,  32'hefcdab89, 1'b0, '0},
      '{REQ_CHAIN, 4'd2,  32'h98badcfe, 1'b0, '0},
      '{REQ_CHAIN, 4'd3,  32'h10325476, 1'b0, '0},
      '{REQ_CHAIN, 4'd4,  32'hffffffff, 1'b0, '0},
      '{REQ_CHAIN, 4'd15, 32'h5a5a5a5a, 1'b0, '0},
      '{REQ_MSG,   4'd15, 32'h00000000, 1'b1,
        '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec}},
      '{REQ_CHAIN, 4'd0,  32'hffffffff, 1'b0, '0},
      '{REQ_MSG,   4'd15, 32'hffffffff, 1'b0, '0}
   };

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                req_type       = REQ_CHAIN;
   logic [INDEX_W-1:0]  req_word_index = '0;
   logic [WORD_W-1:0]   req_word_value = '0;
   logic                busy;
   logic                rsp_valid;
   logic [WORD_W-1:0]   rsp_chain_a;
   logic [WORD_W-1:0]   rsp_chain_b;
   logic [WORD_W-1:0]   rsp_chain_c;
   logic [WORD_W-1:0]   rsp_chain_d;

   // Shadow copy of the block's state, advanced once per accepted transaction.
   logic [WORD_W-1:0]   chain_regs [4];
   logic [WORD_W-1:0]   msg_regs [16];
   // Digests owed by the block, oldest first.
   digest_type          digest_q [$];

   int                  error_count   = 0;
   int                  gap_pct       = 0;
   int                  counted_items = 0;
   longint              cycle_count   = 0;

   md5_block_compress uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_word_index (req_word_index),
      .req_word_value (req_word_value),
      .rsp_valid      (rsp_valid),
      .rsp_chain_a    (rsp_chain_a),
      .rsp_chain_b    (rsp_chain_b),
      .rsp_chain_c    (rsp_chain_c),
      .rsp_chain_d    (rsp_chain_d)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Run the 64 rounds over the shadow message store and fold the result into
   // the shadow chain; return the new chaining value without storing it.
   function automatic digest_type fold_block();
      logic [31:0] a, b, c, d, f, t;
      int          r, grp, g, s;
      digest_type  res;
      a = chain_regs[0];
      b = chain_regs[1];
      c = chain_regs[2];
      d = chain_regs[3];
      for (r = 0; r < 64; r++) begin
         grp = r / 16;
         case (grp)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         s = SHIFT_AMT[grp * 4 + r % 4];
         t = a + f + SINE_K[r] + msg_regs[g];
         t = b + ((t << s) | (t >> (32 - s)));
         a = d;
         d = c;
         c = b;
         b = t;
      end
      res.a = chain_regs[0] + a;
      res.b = chain_regs[1] + b;
      res.c = chain_regs[2] + c;
      res.d = chain_regs[3] + d;
      return res;
   endfunction

   task automatic note_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Apply one accepted transaction to the shadow state. A write of the last
   // message word owes a digest: queue the typed one if the plan gives it.
   task automatic absorb_item(input logic kind, input logic [INDEX_W-1:0] idx,
                              input logic [WORD_W-1:0] val, input logic typed,
                              input digest_type typed_digest);
      digest_type next_chain;
      if (kind == REQ_CHAIN) begin
         if (idx < 4)
            chain_regs[idx[1:0]] = val;
      end else begin
         msg_regs[idx] = val;
         if (idx == LAST_WORD) begin
            next_chain = fold_block();
            chain_regs[0] = next_chain.a;
            chain_regs[1] = next_chain.b;
            chain_regs[2] = next_chain.c;
            chain_regs[3] = next_chain.d;
            digest_q.push_back(typed ? typed_digest : next_chain);
         end
      end
   endtask

   // Present one transaction and hold it until the block takes it. Enter and
   // leave on a rising edge; start is assigned at most once per edge, so a
   // back-to-back transaction keeps start high without a glitch.
   task automatic send_item(input logic kind, input logic [INDEX_W-1:0] idx,
                            input logic [WORD_W-1:0] val, input logic typed,
                            input digest_type typed_digest);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_word_index <= idx;
      req_word_value <= val;
      // Accepted at the first edge that sees start high and busy low.
      do
         @(posedge clock);
      while (busy !== 1'b0);
      absorb_item(kind, idx, val, typed, typed_digest);
      if (!(kind == REQ_CHAIN && idx >= 4))
         counted_items++;
   endtask

   // Skew word values toward the extremes now and then.
   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Drop an ignored chain write (index above three) into the stream.
   task automatic send_stray_chain();
      send_item(REQ_CHAIN, INDEX_W'($urandom_range(15, 4)), rand_word(), 1'b0, '0);
   endtask

   // Well-formed block: maybe reload part of the chain, write words 0..14 in a
   // shuffled order with the odd stray write mixed in, then word 15 to fire.
   task automatic send_block();
      int order [15];
      int j, k, tmp;
      if ($urandom_range(1) == 1) begin
         for (k = 0; k < 4; k++) begin
            if ($urandom_range(3) != 0)
               send_item(REQ_CHAIN, INDEX_W'(k), rand_word(), 1'b0, '0);
         end
      end
      for (k = 0; k < 15; k++)
         order[k] = k;
      for (k = 14; k > 0; k--) begin
         j = $urandom_range(k);
         tmp = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      for (k = 0; k < 15; k++) begin
         if ($urandom_range(15) == 0)
            send_stray_chain();
         send_item(REQ_MSG, INDEX_W'(order[k]), rand_word(), 1'b0, '0);
      end
      send_item(REQ_MSG, LAST_WORD, rand_word(), 1'b0, '0);
   endtask

   // Reuse the stored words: patch a few of them and fire again.
   task automatic send_reuse();
      int n, k;
      n = $urandom_range(3);
      for (k = 0; k < n; k++)
         send_item(REQ_MSG, INDEX_W'($urandom_range(14)), rand_word(), 1'b0, '0);
      send_item(REQ_MSG, LAST_WORD, rand_word(), 1'b0, '0);
   endtask

   // Noise: a short burst of chain writes at any index and partial message
   // writes that never reach word 15.
   task automatic send_noise();
      int n, k;
      n = $urandom_range(4, 1);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(1) == 0)
            send_item(REQ_CHAIN, INDEX_W'($urandom_range(15)), rand_word(), 1'b0, '0);
         else
            send_item(REQ_MSG, INDEX_W'($urandom_range(14)), rand_word(), 1'b0, '0);
      end
   endtask

   // Stimulus: reset, directed plan, then three random phases with different
   // sender idling. The directed plan writes every message word before the
   // first compression, so no later transaction reads an unwritten entry.
   initial begin : stimulus
      int row, phase, target, pick;
      foreach (chain_regs[i])
         chain_regs[i] = '0;
      foreach (msg_regs[i])
         msg_regs[i] = '0;

      // Hold reset at the start, then release it for good.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      gap_pct = PHASE_GAP[0];
      for (row = 0; row < 25; row++) begin
         send_item(DIRECTED[row].kind, DIRECTED[row].index, DIRECTED[row].value,
                   DIRECTED[row].has_digest, DIRECTED[row].digest);
      end

      // Mostly well-formed blocks with random content; the rest is reuse and
      // noise. Advance to the next idling setting after each phase.
      for (phase = 0; phase < 3; phase++) begin
         gap_pct = PHASE_GAP[phase];
         target  = counted_items + ITEMS_PER_PHASE;
         while (counted_items < target) begin
            pick = $urandom_range(99);
            if (pick < 70)
               send_block();
            else if (pick < 82)
               send_reuse();
            else
               send_noise();
         end
      end
      start <= 1'b0;

      // Wait for every owed digest, then let the block settle.
      while (digest_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Result checker: each strobe carries one digest; compare it field by
   // field with the oldest one owed. The receiver never stalls.
   always @(posedge clock) begin : check_digest
      digest_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (digest_q.size() == 0) begin
            note_error($sformatf("digest %h %h %h %h with no compression pending",
                                 rsp_chain_a, rsp_chain_b, rsp_chain_c, rsp_chain_d));
         end else begin
            want = digest_q.pop_front();
            if (rsp_chain_a !== want.a)
               note_error($sformatf("chain_a got %h want %h", rsp_chain_a, want.a));
            if (rsp_chain_b !== want.b)
               note_error($sformatf("chain_b got %h want %h", rsp_chain_b, want.b));
            if (rsp_chain_c !== want.c)
               note_error($sformatf("chain_c got %h want %h", rsp_chain_c, want.c));
            if (rsp_chain_d !== want.d)
               note_error($sformatf("chain_d got %h want %h", rsp_chain_d, want.d));
         end
      end
   end

   // Watchdog: end the run if it drags past the cycle limit.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
   end

endmodule
